@@ design/lcdx_pkg.sv @@
`default_nettype none
package lcdx_pkg;

    localparam int unsigned ADDR_W   = 7;
    localparam int unsigned WIDTH_W  = 7;
    localparam int unsigned CURSOR_W = 7;
    localparam int unsigned WAIT_B_W = 15;
    localparam int unsigned WAIT_A_W = 6;
    localparam int unsigned UNIT_W   = 4;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_EXPANDER_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLIGHT_ON     = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_EXPANDER_ADDRESS = 7'h3F;
    localparam logic [WIDTH_W-1:0] RST_LINE_WIDTH       = 7'd16;
    localparam logic               RST_BACKLIGHT_ON     = 1'b1;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_INIT = 1'b1;

    localparam logic [7:0] CODE_NONE    = 8'h00;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CMD_LINE2    = 8'hC0;

    localparam logic [UNIT_W-1:0] INIT_LAST_UNIT  = 4'd11;
    localparam logic [UNIT_W-1:0] CHAR_FIRST_UNIT = 4'd2;
    localparam logic [UNIT_W-1:0] CHAR_LAST_UNIT  = 4'd3;
    localparam logic [PHASE_W-1:0] PHASE_LAST     = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_ENABLE   = 2'd1;
    localparam logic [WAIT_A_W-1:0] INIT_TAIL_WAIT = 6'd50;

    typedef struct packed {
        logic       init;
        logic       jump;
        logic [7:0] data;
        logic       rs;
    } job_t;

    function automatic logic [3:0] init_nibble(input logic [UNIT_W-1:0] unit);
        logic [3:0] nib;
        case (unit)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd7:             nib = 4'hC;
            4'd9:             nib = 4'h1;
            4'd11:            nib = 4'h6;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [WAIT_B_W-1:0] init_wait(input logic [UNIT_W-1:0] unit);
        logic [WAIT_B_W-1:0] w;
        case (unit)
            4'd0:                   w = 15'd20000;
            4'd1:                   w = 15'd5000;
            4'd2:                   w = 15'd150;
            4'd3, 4'd4, 4'd6, 4'd8: w = 15'd50;
            4'd10:                  w = 15'd2000;
            default:                w = '0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ design/lcdx_front.sv @@
`default_nettype none
module lcdx_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_op,
    input  wire logic [7:0]                  in_char,
    input  wire logic                        in_start,
    input  wire logic [lcdx_pkg::WIDTH_W-1:0] line_width,
    output logic                             q_push,
    input  wire logic                        q_ready,
    output lcdx_pkg::job_t                   q_job
);
    import lcdx_pkg::*;

    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [CURSOR_W-1:0] cur_base;
    logic                accept;
    logic                jump;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign cur_base = in_start ? '0 : cursor_reg;
    assign jump     = (cur_base >= line_width);

    always_comb begin
        cursor_next = cursor_reg;
        q_push      = 1'b0;
        q_job       = '{init: 1'b0, jump: jump, data: in_char, rs: 1'b1};
        if (accept) begin
            if (in_op == OP_INIT) begin
                cursor_next = '0;
                q_push      = 1'b1;
                q_job       = '{init: 1'b1, jump: 1'b0, data: CODE_NONE, rs: 1'b0};
            end else if (in_char == CODE_NONE) begin
                cursor_next = cur_base;
            end else if (in_char == CODE_NEWLINE) begin
                cursor_next = '0;
                q_push      = 1'b1;
                q_job.data  = CMD_LINE2;
                q_job.rs    = 1'b0;
            end else begin
                cursor_next = (jump ? '0 : cur_base) + 1'b1;
                q_push      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else begin
            cursor_reg <= cursor_next;
        end
    end

endmodule
`default_nettype wire

@@ design/lcdx_queue.sv @@
`default_nettype none
module lcdx_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire lcdx_pkg::job_t push_job,
    output logic                push_ready,
    input  wire logic           pop,
    output logic                pop_valid,
    output lcdx_pkg::job_t      pop_job
);
    import lcdx_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != DEPTH[PTR_W:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ design/lcdx_back.sv @@
`default_nettype none
module lcdx_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    input  wire lcdx_pkg::job_t               q_job,
    output logic                              q_pop,
    input  wire logic [lcdx_pkg::ADDR_W-1:0]  expander_address,
    input  wire logic                         backlight_on,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [lcdx_pkg::ADDR_W-1:0]       out_address,
    output logic [7:0]                        out_byte,
    output logic [lcdx_pkg::WAIT_B_W-1:0]     out_wait_before,
    output logic [lcdx_pkg::WAIT_A_W-1:0]     out_wait_after,
    output logic                              out_last
);
    import lcdx_pkg::*;

    job_t                job_reg;
    logic                busy_reg, busy_next;
    logic [UNIT_W-1:0]   unit_reg, unit_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;

    logic                valid_reg, valid_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [7:0]          byte_reg;
    logic [WAIT_B_W-1:0] wait_b_reg;
    logic [WAIT_A_W-1:0] wait_a_reg;
    logic                last_reg;

    logic                adv, emit, final_unit, final_beat, load;
    logic [3:0]          nib;
    logic                rs;
    logic [7:0]          cur_byte;
    logic [WAIT_B_W-1:0] cur_wait_b;
    logic [WAIT_A_W-1:0] cur_wait_a;
    logic [UNIT_W-1:0]   start_unit;

    assign adv        = !valid_reg || out_ready;
    assign emit       = busy_reg && adv;
    assign final_unit = (unit_reg == (job_reg.init ? INIT_LAST_UNIT : CHAR_LAST_UNIT));
    assign final_beat = final_unit && (phase_reg == PHASE_LAST);
    assign load       = q_valid && (!busy_reg || (emit && final_beat));
    assign q_pop      = load;
    assign start_unit = (q_job.init || q_job.jump) ? '0 : CHAR_FIRST_UNIT;

    always_comb begin
        if (job_reg.init) begin
            nib = init_nibble(unit_reg);
            rs  = 1'b0;
        end else begin
            case (unit_reg[1:0])
                2'd0:    nib = CMD_LINE2[7:4];
                2'd1:    nib = CMD_LINE2[3:0];
                2'd2:    nib = job_reg.data[7:4];
                default: nib = job_reg.data[3:0];
            endcase
            rs = unit_reg[1] && job_reg.rs;
        end
        cur_byte   = {nib, backlight_on, (phase_reg == PHASE_ENABLE), 1'b0, rs};
        cur_wait_b = (job_reg.init && phase_reg == '0) ? init_wait(unit_reg) : '0;
        cur_wait_a = (job_reg.init && final_beat) ? INIT_TAIL_WAIT : '0;
    end

    always_comb begin
        busy_next  = busy_reg;
        unit_next  = unit_reg;
        phase_next = phase_reg;
        valid_next = adv ? busy_reg : valid_reg;
        if (emit) begin
            if (phase_reg == PHASE_LAST) begin
                phase_next = '0;
                if (final_unit) begin
                    busy_next = 1'b0;
                end else begin
                    unit_next = unit_reg + 1'b1;
                end
            end else begin
                phase_next = phase_reg + 1'b1;
            end
        end
        if (load) begin
            busy_next  = 1'b1;
            unit_next  = start_unit;
            phase_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= q_job;
        end
        unit_reg  <= unit_next;
        phase_reg <= phase_next;
        if (emit) begin
            addr_reg   <= expander_address;
            byte_reg   <= cur_byte;
            wait_b_reg <= cur_wait_b;
            wait_a_reg <= cur_wait_a;
            last_reg   <= final_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid       = valid_reg;
    assign out_address     = addr_reg;
    assign out_byte        = byte_reg;
    assign out_wait_before = wait_b_reg;
    assign out_wait_after  = wait_a_reg;
    assign out_last        = last_reg;

endmodule
`default_nettype wire

@@ design/char_lcd_i2c_expander_writer_core.sv @@
`default_nettype none
// Channel   Dir  Handshake          Beat contents
// s_        in   s_tvalid/s_tready  tdata: char_code, string_start; tuser: op
// m_        out  m_tvalid/m_tready  tdata: bus_address, bus_byte, wait_before,
//                                   wait_after; tlast: last
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
// One output beat per cycle unless m_tready stalls it; a character gives 6 beats (12 after a line jump),
// an init request 36. The output beat rate of the back sequencer sets the pace.
// A two-entry job queue lets the front take new items while the back drains.
// Reset is synchronous, active low, and clears the cursor, queue and sequencer.
module char_lcd_i2c_expander_writer_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lcdx_pkg::S_DATA_W-1:0]     s_tdata,   // char_code[7:0], string_start[8]
    input  wire logic                              s_tuser,   // op
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lcdx_pkg::M_DATA_W-1:0]          m_tdata,   // bus_address[6:0],
                                                              // bus_byte[14:7],
                                                              // wait_before[29:15],
                                                              // wait_after[35:30]
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lcdx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lcdx_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import lcdx_pkg::*;

    logic [ADDR_W-1:0]   expander_address_reg;
    logic [WIDTH_W-1:0]  line_width_reg;
    logic                backlight_on_reg;

    logic                q_push, q_push_ready, q_pop, q_valid;
    job_t                push_job, pop_job;

    logic [ADDR_W-1:0]   bus_address;
    logic [7:0]          bus_byte;
    logic [WAIT_B_W-1:0] wait_before;
    logic [WAIT_A_W-1:0] wait_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expander_address_reg <= RST_EXPANDER_ADDRESS;
            line_width_reg       <= RST_LINE_WIDTH;
            backlight_on_reg     <= RST_BACKLIGHT_ON;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_EXPANDER_ADDRESS: expander_address_reg <= cfg_wdata[ADDR_W-1:0];
                REG_LINE_WIDTH:       line_width_reg       <= cfg_wdata[WIDTH_W-1:0];
                REG_BACKLIGHT_ON:     backlight_on_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    lcdx_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_char    (s_tdata[7:0]),
        .in_start   (s_tdata[8]),
        .line_width (line_width_reg),
        .q_push     (q_push),
        .q_ready    (q_push_ready),
        .q_job      (push_job)
    );

    lcdx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_job    (pop_job)
    );

    lcdx_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_job            (pop_job),
        .q_pop            (q_pop),
        .expander_address (expander_address_reg),
        .backlight_on     (backlight_on_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_address      (bus_address),
        .out_byte         (bus_byte),
        .out_wait_before  (wait_before),
        .out_wait_after   (wait_after),
        .out_last         (m_tlast)
    );

    assign m_tdata = {4'b0, wait_after, wait_before, bus_byte, bus_address};

endmodule
`default_nettype wire
